### hdl/sjtl_pkg.sv
// Shared types, constants and reset tables for the servo joint tick limiter.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package sjtl_pkg;

  localparam int NUM_JOINTS = 6;
  localparam int TICK_BITS  = 12;
  localparam int JW         = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;

  // Limits packing: min, max, init tick, then the reversed flag
  localparam int LIM_W      = 3 * TICK_BITS + 1;
  localparam int LIMIT_REGS = 6;
  localparam int ANGLE_W    = 28;
  localparam int TPS_W      = 23;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = (LIM_W > ANGLE_W) ? LIM_W : ANGLE_W;

  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_MAP     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_SEC = 3'd7;

  localparam logic [ANGLE_W-1:0] ANGLE_MAP_RESET = 28'd6687002;
  localparam logic [TPS_W-1:0]   TPS_RESET       = 23'd204800;

  // Input and result field widths
  localparam int REQ_W   = 3;
  localparam int JOINT_W = 3;
  localparam int VALUE_W = 17;
  localparam int CHAN_W  = 3;

  typedef logic [REQ_W-1:0]     req_t;
  typedef logic [TICK_BITS-1:0] tick_t;
  typedef logic [LIM_W-1:0]     limits_t;

  localparam req_t REQ_SET_TICK  = 3'd0;
  localparam req_t REQ_SET_PULSE = 3'd1;
  localparam req_t REQ_SET_ANGLE = 3'd2;
  localparam req_t REQ_REL_ANGLE = 3'd3;
  localparam req_t REQ_REL_PULSE = 3'd4;
  localparam req_t REQ_ALL_PULSE = 3'd5;
  localparam req_t REQ_ALL_ANGLE = 3'd6;
  localparam req_t REQ_RESET_ALL = 3'd7;

  // Pulse conversion: (|us| * ticks_per_second + half) / one million
  localparam int PULSE_DIV  = 1000000;
  localparam int PULSE_HALF = 500000;
  localparam int PROD_W     = 40;
  localparam int QUO_W      = 21;

  // Angle conversion: Q10 scale, floor shift
  localparam int ANGLE_FRAC = 10;
  localparam int ANG_P_W    = VALUE_W + 17;
  localparam int TGT_W      = 25;

  typedef logic signed [TGT_W-1:0] tgt_t;

  function automatic limits_t limit_default(input int unsigned j);
    limits_t d;
    case (j)
      1:       d = limits_t'(37'd70785171558);
      2:       d = limits_t'(37'd2065612902);
      3:       d = limits_t'(37'd2401239142);
      4:       d = limits_t'(37'd5152702566);
      5:       d = limits_t'(37'd5152325868);
      default: d = limits_t'(37'd5152702566);
    endcase
    return d;
  endfunction

  function automatic tick_t init_default(input int unsigned j);
    limits_t d;
    d = limit_default(j);
    return d[3*TICK_BITS-1:2*TICK_BITS];
  endfunction

endpackage

### hdl/sjtl_div.sv
// Divider by the constant one million: shift out the factor 64, then multiply
// by the reciprocal of 15625 in two halves on one shared multiplier.
// Depends on sjtl_pkg for PROD_W, QUO_W and PULSE_DIV.
`timescale 1ns / 1ps

module sjtl_div
  import sjtl_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [PROD_W-1:0] dividend,
  output logic              done,
  output logic [QUO_W-1:0]  quotient
);

  // 1000000 = 64 * 15625; the reciprocal is exact for every shifted dividend
  localparam int PRE_SH = 6;
  localparam int Y_W    = PROD_W - PRE_SH;
  localparam int REC_K  = Y_W + 14;
  localparam int REC_W  = 35;
  localparam int HALF_W = 18;
  localparam int MP_W   = Y_W + HALF_W;
  localparam int SUM_W  = MP_W + HALF_W;
  localparam logic [REC_W-1:0] RECIP =
    REC_W'(((64'd1 << (REC_K + PRE_SH)) + 64'(PULSE_DIV) - 64'd1) / 64'(PULSE_DIV));

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_LO   = 2'd1;
  localparam logic [1:0] PH_HI   = 2'd2;
  localparam logic [1:0] PH_SUM  = 2'd3;

  logic [1:0]        ph_r;
  logic              done_r;
  logic [Y_W-1:0]    y_r;
  logic [MP_W-1:0]   lo_r;
  logic [MP_W-1:0]   hi_r;
  logic [QUO_W-1:0]  q_r;
  logic [HALF_W-1:0] m_half;
  logic [MP_W-1:0]   prod;
  logic [SUM_W-1:0]  sum;

  // Low half of the reciprocal first, then the high half
  assign m_half = (ph_r == PH_LO) ? RECIP[HALF_W-1:0] : HALF_W'(RECIP[REC_W-1:HALF_W]);
  assign prod   = MP_W'(y_r) * MP_W'(m_half);
  assign sum    = {hi_r, HALF_W'(0)} + SUM_W'(lo_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= PH_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (ph_r)
        PH_IDLE: begin
          if (start) begin
            ph_r <= PH_LO;
          end
        end
        PH_LO:   ph_r <= PH_HI;
        PH_HI:   ph_r <= PH_SUM;
        PH_SUM: begin
          ph_r   <= PH_IDLE;
          done_r <= 1'b1;
        end
        default: ph_r <= PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      y_r <= dividend[PROD_W-1:PRE_SH];
    end
    if (ph_r == PH_LO) begin
      lo_r <= prod;
    end
    if (ph_r == PH_HI) begin
      hi_r <= prod;
    end
    if (ph_r == PH_SUM) begin
      q_r <= sum[REC_K +: QUO_W];
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

### hdl/servo_joint_tick_limiter_top.sv
// Top level of the servo joint tick limiter: config registers, joint tick
// memory, command sequencer and result register. Depends on sjtl_pkg, sjtl_div.
`timescale 1ns / 1ps

// Servo joint tick limiter. One request at a time sets or moves the stored
// tick of one joint, or of all joints for the broadcast and reset-all codes;
// every joint written gives one result (channel, PWM off-tick mirrored for
// reversed joints, stored tick, last flag). Joint ticks live in a small
// synchronous memory with a registered read; per-entry valid bits stand in
// for the reset values, so no clearing pass follows reset. Steps per request:
// accept, multiply, prepare, target, then one write step per joint written,
// each of which waits while out_stall holds a result. Requests in pulse units
// add a divide by one million (a reciprocal multiply in two halves) between
// prepare and target, the longest path through the block. A request naming a
// joint beyond the last is dropped in its accept cycle with no result.
// in_stall stays high from accept until the last result has entered the
// output register; that register holds a finished result while the next
// request is taken. Results stall only under out_stall. Configuration writes
// are taken every cycle (cfg_ready is tied high) and must arrive only while
// the block is idle.

module servo_joint_tick_limiter_top
  import sjtl_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // request channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [REQ_W-1:0]      in_req_type,
  input  logic [JOINT_W-1:0]    in_joint,
  input  logic signed [VALUE_W-1:0] in_value,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [CHAN_W-1:0]     out_channel,
  output logic [TICK_BITS-1:0]  out_pwm_off,
  output logic [TICK_BITS-1:0]  out_joint_tick,
  output logic                  out_last,
  // configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_PREP = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_TGT  = 3'd4;
  localparam logic [2:0] S_WR   = 3'd5;

  // Configuration registers
  limits_t          limits_r [NUM_JOINTS];
  logic [ANGLE_W-1:0] angle_map_r;
  logic [TPS_W-1:0] tps_r;

  // Joint tick memory and its valid bits
  tick_t            tick_mem [NUM_JOINTS];
  logic [NUM_JOINTS-1:0] tick_vld_r;
  tick_t            rd_data_r;
  logic             rd_vld_r;

  // Sequencer state
  logic [2:0]       state_r, state_nxt;
  req_t             req_r;
  logic [JW-1:0]    jsel_r;
  logic [JW-1:0]    jcnt_r;
  logic             bcast_r;
  logic signed [VALUE_W-1:0] value_r;
  tick_t            base_r;
  logic signed [ANG_P_W-1:0] ang_p_r;
  logic [PROD_W-1:0] pulse_p_r;
  tgt_t             target_r;

  // Result register
  logic             out_valid_r;
  logic [CHAN_W-1:0] out_channel_r;
  tick_t            out_pwm_off_r;
  tick_t            out_joint_tick_r;
  logic             out_last_r;

  logic             in_fire;
  logic             in_keep;
  logic             pulse_req;
  logic             div_start;
  logic             div_done;
  logic [QUO_W-1:0] div_q;
  logic [VALUE_W-1:0] mag;
  tgt_t             ang_d;
  tgt_t             qpos;
  tgt_t             sq;
  tgt_t             tgt_calc;
  logic [JW-1:0]    cur;
  limits_t          lim;
  tick_t            mn, mx, ini;
  logic             rev;
  tgt_t             tw;
  tick_t            tick_new;
  tick_t            off_new;
  logic             out_free;
  logic             wr_fire;
  logic             wr_last;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != S_IDLE);
  assign in_fire   = in_valid && !in_stall;
  // Drop single-joint requests that name a joint beyond the last
  assign in_keep   = (in_req_type >= REQ_ALL_PULSE) || (int'(in_joint) < NUM_JOINTS);

  assign pulse_req = (req_r == REQ_SET_PULSE) || (req_r == REQ_REL_PULSE) ||
                     (req_r == REQ_ALL_PULSE);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < NUM_JOINTS; j++) begin
        limits_r[j] <= limit_default(j);
      end
      angle_map_r <= ANGLE_MAP_RESET;
      tps_r       <= TPS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      for (int j = 0; j < NUM_JOINTS; j++) begin
        if (j < LIMIT_REGS && int'(cfg_index) == j) begin
          limits_r[j] <= cfg_data[LIM_W-1:0];
        end
      end
      if (cfg_index == REG_ANGLE_MAP) begin
        angle_map_r <= cfg_data[ANGLE_W-1:0];
      end
      if (cfg_index == REG_TICKS_PER_SEC) begin
        tps_r <= cfg_data[TPS_W-1:0];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    div_start = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_fire && in_keep) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL:  state_nxt = S_PREP;
      S_PREP: begin
        if (pulse_req) begin
          div_start = 1'b1;
          state_nxt = S_DIV;
        end else begin
          state_nxt = S_TGT;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_TGT;
        end
      end
      S_TGT:  state_nxt = S_WR;
      S_WR: begin
        if (wr_fire && wr_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Capture the request and read the addressed joint's stored tick
  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_r   <= in_req_type;
      jsel_r  <= JW'(in_joint);
      value_r <= in_value;
      bcast_r <= (in_req_type >= REQ_ALL_PULSE);
      jcnt_r  <= '0;
      if (in_keep && in_req_type < REQ_ALL_PULSE) begin
        rd_data_r <= tick_mem[JW'(in_joint)];
        rd_vld_r  <= tick_vld_r[JW'(in_joint)];
      end
    end else if (wr_fire && !wr_last) begin
      jcnt_r <= jcnt_r + 1'b1;
    end
  end

  // Multiply cycle: angle and pulse products, base tick with reset fallback
  assign mag = value_r[VALUE_W-1] ? VALUE_W'(-value_r) : VALUE_W'(value_r);

  always_ff @(posedge clk) begin
    if (state_r == S_MUL) begin
      ang_p_r   <= value_r * $signed({1'b0, angle_map_r[15:0]});
      pulse_p_r <= PROD_W'(mag) * PROD_W'(tps_r);
      base_r    <= rd_vld_r ? rd_data_r : init_default(int'(jsel_r));
    end
  end

  sjtl_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (pulse_p_r + PROD_W'(PULSE_HALF)),
    .done     (div_done),
    .quotient (div_q)
  );

  // Target cycle: floor shift for angles, signed rounding for pulses
  assign ang_d = tgt_t'($signed(ang_p_r[ANG_P_W-1:ANGLE_FRAC]));
  assign qpos  = tgt_t'(div_q);
  assign sq    = value_r[VALUE_W-1] ? -qpos : qpos;

  always_comb begin
    case (req_r)
      REQ_SET_TICK:  tgt_calc = tgt_t'(value_r);
      REQ_SET_PULSE,
      REQ_ALL_PULSE: tgt_calc = sq;
      REQ_SET_ANGLE,
      REQ_ALL_ANGLE: tgt_calc = ang_d + tgt_t'(angle_map_r[27:16]);
      REQ_REL_ANGLE: tgt_calc = tgt_t'(base_r) + ang_d;
      REQ_REL_PULSE: tgt_calc = tgt_t'(base_r) + sq;
      default:       tgt_calc = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == S_TGT) begin
      target_r <= tgt_calc;
    end
  end

  // Write cycle: clamp (min test first), mirror for reversed joints
  assign cur = bcast_r ? jcnt_r : jsel_r;
  assign lim = limits_r[cur];
  assign mn  = lim[TICK_BITS-1:0];
  assign mx  = lim[2*TICK_BITS-1:TICK_BITS];
  assign ini = lim[3*TICK_BITS-1:2*TICK_BITS];
  assign rev = lim[3*TICK_BITS];
  assign tw  = (req_r == REQ_RESET_ALL) ? tgt_t'(ini) : target_r;

  always_comb begin
    if (tw < tgt_t'(mn)) begin
      tick_new = mn;
    end else if (tw > tgt_t'(mx)) begin
      tick_new = mx;
    end else begin
      tick_new = tw[TICK_BITS-1:0];
    end
    off_new = rev ? tick_t'(mn + mx - tick_new) : tick_new;
  end

  assign out_free = !out_valid_r || !out_stall;
  assign wr_fire  = (state_r == S_WR) && out_free;
  assign wr_last  = !bcast_r || (jcnt_r == JW'(NUM_JOINTS - 1));

  always_ff @(posedge clk) begin
    if (wr_fire) begin
      tick_mem[cur] <= tick_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_vld_r <= '0;
    end else if (wr_fire) begin
      tick_vld_r[cur] <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register: hold under stall, load on each joint write
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (wr_fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_fire) begin
      out_channel_r    <= CHAN_W'(cur);
      out_pwm_off_r    <= off_new;
      out_joint_tick_r <= tick_new;
      out_last_r       <= wr_last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_channel    = out_channel_r;
  assign out_pwm_off    = out_pwm_off_r;
  assign out_joint_tick = out_joint_tick_r;
  assign out_last       = out_last_r;

endmodule

### hdl/sjtl_checker.sv
// Port-level checks for the servo joint tick limiter, bound to the top level.
// Depends on sjtl_pkg and servo_joint_tick_limiter_top.
`timescale 1ns / 1ps

module sjtl_checker
  import sjtl_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic [REQ_W-1:0]      in_req_type,
  input logic [JOINT_W-1:0]    in_joint,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [CHAN_W-1:0]     out_channel,
  input logic [TICK_BITS-1:0]  out_pwm_off,
  input logic [TICK_BITS-1:0]  out_joint_tick,
  input logic                  out_last
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_channel) &&
      $stable(out_pwm_off) && $stable(out_joint_tick) && $stable(out_last))
    else $error("stalled result changed");

  // A request that writes a joint keeps the block busy the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_req_type >= REQ_ALL_PULSE || int'(in_joint) < NUM_JOINTS)
      |=> in_stall)
    else $error("request accepted but block not busy");

  // No new request while a broadcast is still producing results
  a_busy_mid_broadcast: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> in_stall)
    else $error("request taken before broadcast finished");

  a_channel_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> int'(out_channel) < NUM_JOINTS)
    else $error("result channel out of range");

  // A result on the final channel must carry the last flag
  a_last_channel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> int'(out_channel) < NUM_JOINTS - 1)
    else $error("non-final result on final channel");

endmodule

bind servo_joint_tick_limiter_top sjtl_checker u_sjtl_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .in_req_type    (in_req_type),
  .in_joint       (in_joint),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_channel    (out_channel),
  .out_pwm_off    (out_pwm_off),
  .out_joint_tick (out_joint_tick),
  .out_last       (out_last)
);
